@@ src/grm_pkg.sv @@
// Shared constants for the grid ray march block: field layout, register indexes, sine constants.
package grm_pkg;

  // Sine polynomial coefficients, Q16
  localparam logic [16:0] SIN_A = 17'd102944;
  localparam logic [16:0] SIN_B = 17'd42047;
  localparam logic [16:0] SIN_C = 17'd4640;
  localparam logic [15:0] UNIT_ONE = 16'd32768;

  // Configuration register indexes
  localparam logic [1:0] REG_TILE_PIXELS = 2'd0;
  localparam logic [1:0] REG_MAP_COLUMNS = 2'd1;
  localparam logic [1:0] REG_MAP_ROWS    = 2'd2;

  // Item kinds carried on tuser
  localparam logic OP_WRITE = 1'b0;

  // Input tdata layout, lowest bit first
  localparam int IN_TDATA_W = 96;
  localparam int CELL_LO    = 0;
  localparam int SOLID_LO   = 12;
  localparam int OX_LO      = 13;
  localparam int OY_LO      = 37;
  localparam int ANG_LO     = 61;
  localparam int RANGE_LO   = 73;

  // Last quotient bit index of the divider (24 quotient bits)
  localparam logic [4:0] DIV_LAST = 5'd23;

endpackage

@@ src/grid_ray_march.sv @@
// Grid ray march: one-bit tile map in a synchronous memory and a DDA cell walker.
//
// Items enter on the s_axis channel. tuser selects the kind: 0 writes one map
// cell (cell_index, cell_solid), 1 casts a ray from origin_x/origin_y along
// angle, limited to max_range pixels. Every item returns one result on m_axis:
// tdata is the Q16.8 distance to the first solid cell or map edge boundary (or
// the range), tuser flags that a wall was found. Writes return distance zero.
// Configuration goes through the cfg channel (index 0 tile pixels, 1 columns,
// 2 rows); it is always ready and must be used only while the block is idle.
// A write item goes through the done state to the output register. A cast
// first sets up the direction sines on one shared multiplier and runs two
// 24-step origin divisions, then visits each cell with a product compare and
// then the map read, then on a hit or at the map edge runs a 24-step distance
// division, and finally loads the output register. The single map read port
// per step sets the walk rate. After reset the map is cleared one cell per
// cycle, all MAP_SIDE*MAP_SIDE cells, with s_axis_tready low. One result is
// held in an output register; the next item is accepted while it waits, and
// its result holds until the receiver takes the previous one.
module grid_ray_march import grm_pkg::*; #(
  parameter int MAP_SIDE   = 64,
  parameter int ANGLE_BITS = 12
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  // cell_index[11:0], cell_solid[12], origin_x[36:13], origin_y[60:37],
  // angle[72:61], max_range[88:73], zero fill
  input  logic [IN_TDATA_W-1:0] s_axis_tdata,
  // opcode[0]
  input  logic [0:0]            s_axis_tuser,
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  // distance[23:0]
  output logic [23:0]           m_axis_tdata,
  // wall_found[0]
  output logic [0:0]            m_axis_tuser,
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [1:0]            cfg_index_i,
  input  logic [8:0]            cfg_data_i
);

  localparam int CELLS = MAP_SIDE * MAP_SIDE;
  localparam int AW    = $clog2(CELLS);
  localparam int CW    = $clog2(MAP_SIDE + 1);
  localparam int RW    = ANGLE_BITS - 2;
  localparam int ZSH   = 18 - ANGLE_BITS;
  localparam logic [ANGLE_BITS-1:0] QUARTER = ANGLE_BITS'(1) << RW;

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_SIN, S_LIMX, S_LIMY, S_DIVX, S_DIVY,
    S_ADDR0, S_ADDR1, S_STEP, S_CHK, S_FDIV, S_DONE
  } state_e;

  state_e state_q;

  // configuration
  logic [8:0] tile_q;
  logic [6:0] cols_q, rows_q;
  logic [8:0] tile_eff;
  logic [CW-1:0] cols_eff, rows_eff;
  logic [16:0] unit;

  // item registers
  logic [23:0] ox_q, oy_q;
  logic [ANGLE_BITS-1:0] ang_q;
  logic [15:0] rng_q;

  // direction and walk state
  logic        ax_q;
  logic [2:0]  ph_q;
  logic [15:0] z2_q;
  logic [15:0] mx_q, my_q;
  logic        negx_q, negy_q;
  logic [40:0] limx_q, limy_q;
  logic [25:0] bx_q, by_q;
  logic [17:0] cx_q, cy_q;
  logic [26:0] addr_q;
  logic [25:0] hb_q;
  logic [15:0] hm_q;
  logic        outr_q, oob_q;

  // shared multiplier and walk products
  logic [16:0] mul_a, mul_b;
  logic [33:0] mul_p_q;
  logic [41:0] px_q, py_q;

  // divider
  logic [16:0] div_rem_q, div_den_q, rem_n;
  logic [23:0] div_num_q, num_n;
  logic [4:0]  div_cnt_q;
  logic [17:0] div_t;
  logic        div_ge;

  // map memory
  logic          mem_q [CELLS];
  logic          rd_q;
  logic [AW-1:0] rd_addr;
  logic [AW-1:0] clr_cnt_q;
  logic          wr_en;

  // results
  logic [23:0] res_dist_q, m_dist_q;
  logic        res_wall_q, m_wall_q, m_valid_q;

  logic acc;
  logic op_in;
  logic [11:0] cell_in;
  logic solid_in;

  assign acc      = s_axis_tvalid && s_axis_tready;
  assign op_in    = s_axis_tuser[0];
  assign cell_in  = s_axis_tdata[CELL_LO +: 12];
  assign solid_in = s_axis_tdata[SOLID_LO];

  assign s_axis_tready = (state_q == S_IDLE);
  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_dist_q;
  assign m_axis_tuser  = m_wall_q;
  assign cfg_ready_o   = 1'b1;

  // Saturate the configuration to legal ranges
  always_comb begin
    if (tile_q == 9'd0) tile_eff = 9'd1;
    else if (tile_q > 9'd256) tile_eff = 9'd256;
    else tile_eff = tile_q;
    if (cols_q == 7'd0) cols_eff = CW'(1);
    else if (32'(cols_q) > MAP_SIDE) cols_eff = CW'(MAP_SIDE);
    else cols_eff = CW'(cols_q);
    if (rows_q == 7'd0) rows_eff = CW'(1);
    else if (32'(rows_q) > MAP_SIDE) rows_eff = CW'(MAP_SIDE);
    else rows_eff = CW'(rows_q);
  end
  assign unit = {tile_eff[8:0], 8'd0};

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tile_q <= 9'd16;
      cols_q <= 7'd64;
      rows_q <= 7'd64;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        REG_TILE_PIXELS: tile_q <= cfg_data_i;
        REG_MAP_COLUMNS: cols_q <= cfg_data_i[6:0];
        REG_MAP_ROWS:    rows_q <= cfg_data_i[6:0];
        default:         ;
      endcase
    end
  end

  // Quarter-wave sine of the axis being set up
  logic [ANGLE_BITS-1:0] ang_sel;
  logic [1:0]  quad;
  logic [RW:0] rr;
  logic        full;
  logic [15:0] zval;
  logic [17:0] ysum;
  logic [16:0] yh;
  logic [15:0] mag;

  assign ang_sel = ax_q ? ang_q : ang_q + QUARTER;
  assign quad    = ang_sel[ANGLE_BITS-1:ANGLE_BITS-2];
  assign rr      = quad[0] ? ((RW+1)'(1) << RW) - {1'b0, ang_sel[RW-1:0]}
                           : {1'b0, ang_sel[RW-1:0]};
  assign full    = rr[RW];
  assign zval    = 16'(rr[RW-1:0]) << ZSH;
  assign ysum    = 18'(mul_p_q[33:16]) + 18'd1;
  assign yh      = ysum[17:1];
  assign mag     = (full || yh > 17'(UNIT_ONE)) ? UNIT_ONE : yh[15:0];

  // Pick multiplier operands for the current setup step
  always_comb begin
    mul_a = 17'd0;
    mul_b = 17'd0;
    case (state_q)
      S_SIN: begin
        case (ph_q)
          3'd0: begin mul_a = 17'(zval); mul_b = 17'(zval); end
          3'd1: begin mul_a = 17'(mul_p_q[31:16]); mul_b = SIN_C; end
          3'd2: begin mul_a = 17'(z2_q); mul_b = SIN_B - 17'(mul_p_q[31:16]); end
          3'd3: begin mul_a = 17'(zval); mul_b = SIN_A - 17'(mul_p_q[31:16]); end
          default: ;
        endcase
      end
      S_LIMX:  begin mul_a = 17'(rng_q); mul_b = 17'(mx_q); end
      S_LIMY:  begin mul_a = 17'(rng_q); mul_b = 17'(my_q); end
      S_ADDR0: begin mul_a = 17'(cy_q[15:0]); mul_b = 17'(cols_eff); end
      default: ;
    endcase
  end

  // Register the shared product and the walk products
  always_ff @(posedge clk_i) begin
    mul_p_q <= 34'(mul_a) * 34'(mul_b);
    px_q    <= 42'(bx_q) * 42'(my_q);
    py_q    <= 42'(by_q) * 42'(mx_q);
  end

  // One restoring division step
  assign div_t  = {div_rem_q, div_num_q[23]};
  assign div_ge = div_t >= {1'b0, div_den_q};
  assign rem_n  = div_ge ? 17'(div_t - {1'b0, div_den_q}) : div_t[16:0];
  assign num_n  = {div_num_q[22:0], div_ge};

  // Origin cell offsets out of the divider
  logic [15:0] off_n;
  logic [25:0] bstart;
  logic        neg_cur;
  assign off_n   = {rem_n[7:0], (state_q == S_DIVX) ? ox_q[7:0] : oy_q[7:0]};
  assign neg_cur = (state_q == S_DIVX) ? negx_q : negy_q;
  assign bstart  = neg_cur ? 26'(off_n) : 26'(unit - 17'(off_n));

  // Walk step: nearer boundary advances, ties go to y
  logic        selx;
  logic [25:0] bsel;
  logic [15:0] msel;
  logic [40:0] lsel;
  logic        outr_n, oob_n;
  logic [17:0] cx_n, cy_n;
  logic [26:0] addr_n, colsx;

  assign selx  = px_q < py_q;
  assign bsel  = selx ? bx_q : by_q;
  assign msel  = selx ? mx_q : my_q;
  assign lsel  = selx ? limx_q : limy_q;
  // Out of range when b * 2^15 reaches (range * 256 + 1) * m
  assign outr_n = {bsel, 15'd0} >= lsel;
  assign colsx = 27'(cols_eff);
  assign cx_n  = selx ? (negx_q ? cx_q - 18'd1 : cx_q + 18'd1) : cx_q;
  assign cy_n  = selx ? cy_q : (negy_q ? cy_q - 18'd1 : cy_q + 18'd1);
  assign addr_n = selx ? (negx_q ? addr_q - 27'd1 : addr_q + 27'd1)
                       : (negy_q ? addr_q - colsx : addr_q + colsx);
  assign oob_n = cx_n[17] || (cx_n >= 18'(cols_eff))
              || cy_n[17] || (cy_n >= 18'(rows_eff));
  assign rd_addr = addr_n[AW-1:0];

  assign wr_en = acc && (op_in == OP_WRITE) && (32'(cell_in) < CELLS);

  // Map memory: clear sweep, cell writes, registered read
  always_ff @(posedge clk_i) begin
    if (state_q == S_CLEAR) mem_q[clr_cnt_q] <= 1'b0;
    else if (wr_en) mem_q[AW'(cell_in)] <= solid_in;
    rd_q <= mem_q[rd_addr];
  end

  // Sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_CLEAR;
      clr_cnt_q <= '0;
      m_valid_q <= 1'b0;
      ax_q      <= 1'b0;
      ph_q      <= 3'd0;
      div_cnt_q <= 5'd0;
    end else begin
      if (m_axis_tready && state_q != S_DONE) m_valid_q <= 1'b0;
      case (state_q)
        S_CLEAR: begin
          clr_cnt_q <= clr_cnt_q + AW'(1);
          if (clr_cnt_q == AW'(CELLS - 1)) state_q <= S_IDLE;
        end
        S_IDLE: begin
          if (acc) begin
            ox_q  <= s_axis_tdata[OX_LO +: 24];
            oy_q  <= s_axis_tdata[OY_LO +: 24];
            ang_q <= ANGLE_BITS'(s_axis_tdata[ANG_LO +: 12]);
            rng_q <= s_axis_tdata[RANGE_LO +: 16];
            ax_q  <= 1'b0;
            ph_q  <= 3'd0;
            if (op_in == OP_WRITE) begin
              res_dist_q <= 24'd0;
              res_wall_q <= 1'b0;
              state_q    <= S_DONE;
            end else begin
              state_q <= S_SIN;
            end
          end
        end
        S_SIN: begin
          if (ph_q == 3'd1) z2_q <= mul_p_q[31:16];
          if (ph_q == 3'd4) begin
            ph_q <= 3'd0;
            if (!ax_q) begin
              mx_q   <= mag;
              negx_q <= quad[1] && (mag != 16'd0);
              ax_q   <= 1'b1;
            end else begin
              my_q    <= mag;
              negy_q  <= quad[1] && (mag != 16'd0);
              state_q <= S_LIMX;
            end
          end else begin
            ph_q <= ph_q + 3'd1;
          end
        end
        S_LIMX: state_q <= S_LIMY;
        S_LIMY: begin
          limx_q    <= 41'({mul_p_q[31:0], 8'd0}) + 41'(mx_q);
          div_rem_q <= 17'd0;
          div_num_q <= {8'd0, ox_q[23:8]};
          div_den_q <= {8'd0, tile_eff};
          div_cnt_q <= 5'd0;
          state_q   <= S_DIVX;
        end
        S_DIVX, S_DIVY: begin
          if (state_q == S_DIVX && div_cnt_q == 5'd0)
            limy_q <= 41'({mul_p_q[31:0], 8'd0}) + 41'(my_q);
          if (div_cnt_q == DIV_LAST) begin
            div_cnt_q <= 5'd0;
            if (state_q == S_DIVX) begin
              cx_q      <= 18'(num_n[15:0]);
              bx_q      <= bstart;
              div_rem_q <= 17'd0;
              div_num_q <= {8'd0, oy_q[23:8]};
              state_q   <= S_DIVY;
            end else begin
              cy_q    <= 18'(num_n[15:0]);
              by_q    <= bstart;
              state_q <= S_ADDR0;
            end
          end else begin
            div_rem_q <= rem_n;
            div_num_q <= num_n;
            div_cnt_q <= div_cnt_q + 5'd1;
          end
        end
        S_ADDR0: state_q <= S_ADDR1;
        S_ADDR1: begin
          addr_q  <= 27'(mul_p_q) + 27'(cx_q);
          state_q <= S_STEP;
        end
        S_STEP: begin
          hb_q   <= bsel;
          hm_q   <= msel;
          outr_q <= outr_n;
          oob_q  <= oob_n;
          cx_q   <= cx_n;
          cy_q   <= cy_n;
          addr_q <= addr_n;
          if (selx) bx_q <= bx_q + 26'(unit);
          else by_q <= by_q + 26'(unit);
          state_q <= S_CHK;
        end
        S_CHK: begin
          if (outr_q) begin
            res_dist_q <= {rng_q, 8'd0};
            res_wall_q <= 1'b0;
            state_q    <= S_DONE;
          end else if (oob_q || rd_q) begin
            div_rem_q <= 17'(hb_q[25:9]);
            div_num_q <= {hb_q[8:0], 15'd0};
            div_den_q <= {1'b0, hm_q};
            div_cnt_q <= 5'd0;
            state_q   <= S_FDIV;
          end else begin
            state_q <= S_STEP;
          end
        end
        S_FDIV: begin
          if (div_cnt_q == DIV_LAST) begin
            div_cnt_q  <= 5'd0;
            res_dist_q <= num_n;
            res_wall_q <= 1'b1;
            state_q    <= S_DONE;
          end else begin
            div_rem_q <= rem_n;
            div_num_q <= num_n;
            div_cnt_q <= div_cnt_q + 5'd1;
          end
        end
        S_DONE: begin
          if (!m_valid_q || m_axis_tready) begin
            m_valid_q <= 1'b1;
            m_dist_q  <= res_dist_q;
            m_wall_q  <= res_wall_q;
            state_q   <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  // Divider remainder stays below the divisor
  a_div_rem: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DIVX || state_q == S_DIVY || state_q == S_FDIV) |->
      (div_rem_q < div_den_q))
    else $error("divider remainder not below divisor");

  // A wall distance never exceeds the range
  a_dist_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_FDIV && div_cnt_q == DIV_LAST) |-> (num_n <= {rng_q, 8'd0}))
    else $error("wall distance beyond range");

  // An accepted item keeps the input closed for the next cycle
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    acc |=> !s_axis_tready)
    else $error("input accepted twice in a row");

endmodule
